@@ hw/rtl/jpi_pkg.sv @@
`default_nettype none

package jpi_pkg;

    localparam int AXES     = 3;
    localparam int POS_W    = 21;
    localparam int SPD_W    = 6;
    localparam int MS_W     = 16;
    localparam int RATE_W   = 10;
    localparam int FEED_W   = 19;

    // internal widths
    localparam int MAG_W    = 6;
    localparam int MSC_W    = 7;
    localparam int S_W      = 12;
    localparam int RR_W     = 2 * RATE_W;
    localparam int P_W      = 32;
    localparam int N_W      = P_W + 8;
    localparam int ROOT_W   = N_W / 2;
    localparam int REM_W    = ROOT_W + 4;
    localparam int FM_W     = FEED_W + MSC_W;
    localparam int X_W      = 31;
    localparam int Q_W      = 20;
    localparam int CNT_W    = 5;
    localparam int AX_W     = 2;

    localparam logic [MSC_W-1:0]  MS_MAX    = 7'd100;
    localparam logic [FEED_W-1:0] FEED_MAX  = 19'h7FFFF;
    localparam logic [P_W-1:0]    P_MIN     = 32'd3;
    localparam logic [31:0]       MOVE_DIV  = 32'd4000;
    // floor(2^43 / 4000)
    localparam logic [31:0]       RECIP_M   = 32'd2199023255;
    localparam int                RECIP_SH  = 43;

    // configuration port
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;
    localparam logic [IDX_W-1:0] REG_RATE_XY = 3'd0;
    localparam logic [IDX_W-1:0] REG_RATE_Z  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LIMIT_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT_Z = 3'd4;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate_xy;
        logic [RATE_W-1:0] rate_z;
        pos_t              limit_x;
        pos_t              limit_y;
        pos_t              limit_z;
    } cfg_t;

    typedef struct packed {
        logic            accept;
        logic            prep;
        logic            prod;
        logic            sqrt_step;
        logic            feed;
        logic            mul;
        logic            recip;
        logic            corr;
        logic            upd;
        logic            result;
        logic [AX_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic go;
        logic out_blocked;
    } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/jpi_regs.sv @@
`default_nettype none

module jpi_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [jpi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output jpi_pkg::cfg_t              cfg
);
    import jpi_pkg::*;

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr;

    assign idx = paddr[ADDR_W-1:2];
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_xy <= 10'd120;
            cfg_reg.rate_z  <= 10'd10;
            cfg_reg.limit_x <= 21'd312320;
            cfg_reg.limit_y <= 21'd312320;
            cfg_reg.limit_z <= 21'd312320;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_RATE_XY: cfg_reg.rate_xy <= pwdata[RATE_W-1:0];
                REG_RATE_Z:  cfg_reg.rate_z  <= pwdata[RATE_W-1:0];
                REG_LIMIT_X: cfg_reg.limit_x <= pwdata[POS_W-1:0];
                REG_LIMIT_Y: cfg_reg.limit_y <= pwdata[POS_W-1:0];
                REG_LIMIT_Z: cfg_reg.limit_z <= pwdata[POS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RATE_XY: prdata = 32'(cfg_reg.rate_xy);
            REG_RATE_Z:  prdata = 32'(cfg_reg.rate_z);
            REG_LIMIT_X: prdata = 32'(cfg_reg.limit_x);
            REG_LIMIT_Y: prdata = 32'(cfg_reg.limit_y);
            REG_LIMIT_Z: prdata = 32'(cfg_reg.limit_z);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/jpi_ctrl.sv @@
`default_nettype none

module jpi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  jpi_pkg::stat_t stat,
    output jpi_pkg::cmd_t  cmd
);
    import jpi_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_PROD  = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_FEED  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_RECIP = 4'd6;
    localparam logic [3:0] S_CORR  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AX_W-1:0]  axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // load items already took effect on accept
                if (stat.is_load)
                    state_next = S_DONE;
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (!stat.go)
                    state_next = S_DONE;
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                        state_next = S_FEED;
                end
            end
            S_FEED:
            begin
                cmd.feed   = 1'b1;
                axis_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (axis_reg == AX_W'(AXES - 1))
                    state_next = S_DONE;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!stat.out_blocked)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/jpi_dp.sv @@
`default_nettype none

module jpi_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jpi_pkg::cmd_t                     cmd,
    output jpi_pkg::stat_t                    stat,
    input  jpi_pkg::cfg_t                     cfg,
    input  logic                              op,
    input  logic signed [jpi_pkg::SPD_W-1:0]  speed_x,
    input  logic signed [jpi_pkg::SPD_W-1:0]  speed_y,
    input  logic signed [jpi_pkg::SPD_W-1:0]  speed_z,
    input  logic [jpi_pkg::MS_W-1:0]          elapsed_ms,
    input  jpi_pkg::pos_t                     load_x,
    input  jpi_pkg::pos_t                     load_y,
    input  jpi_pkg::pos_t                     load_z,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              moved,
    output jpi_pkg::pos_t                     pos_x,
    output jpi_pkg::pos_t                     pos_y,
    output jpi_pkg::pos_t                     pos_z,
    output logic [jpi_pkg::FEED_W-1:0]        feed,
    output logic                              rumble
);
    import jpi_pkg::*;

    // item registers
    logic                     op_reg;
    logic signed [SPD_W-1:0]  spd_reg [AXES];
    logic [MSC_W-1:0]         ms_reg;
    pos_t                     cur_reg [AXES];

    // arithmetic registers
    logic [S_W-1:0]           s_reg;
    logic [RR_W-1:0]          rr_reg;
    logic [P_W-1:0]           p_reg;
    logic [N_W-1:0]           n_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [FEED_W-1:0]        feed_reg;
    logic [FM_W-1:0]          fm_reg;
    logic [X_W-1:0]           x_reg;
    logic [Q_W-1:0]           q0_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     moved_reg;
    logic                     rumble_reg;

    // result register
    logic                     out_valid_reg;
    logic                     out_moved_reg;
    pos_t                     out_pos_reg [AXES];
    logic [FEED_W-1:0]        out_feed_reg;
    logic                     out_rumble_reg;

    logic [MAG_W-1:0]         mag [AXES];
    logic [S_W-1:0]           s_sum;
    logic [RATE_W-1:0]        rate_sel;
    logic [RR_W-1:0]          rr;
    logic [P_W-1:0]           p;
    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         trial;
    logic [FEED_W-1:0]        root_sat;
    logic [FM_W-1:0]          fm;
    logic [MAG_W-1:0]         mag_sel;
    logic [31:0]              x_full;
    logic [X_W+31:0]          recip_prod;
    logic [31:0]              q0k;
    logic [31:0]              rem_d;
    logic [Q_W-1:0]           q;
    pos_t                     cur_sel;
    pos_t                     lim_sel;
    logic                     neg;
    logic                     under;
    logic                     over;
    logic                     before_bound;
    logic [POS_W:0]           sum;
    pos_t                     new_pos;
    logic [MSC_W-1:0]         ms_clamp;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
            mag[a] = spd_reg[a][SPD_W-1] ? MAG_W'(-spd_reg[a]) : MAG_W'(spd_reg[a]);
    end

    assign s_sum    = S_W'(mag[0]) * S_W'(mag[0]) + S_W'(mag[1]) * S_W'(mag[1])
                    + S_W'(mag[2]) * S_W'(mag[2]);
    assign rate_sel = (spd_reg[2] != '0) ? cfg.rate_z : cfg.rate_xy;
    assign rr       = RR_W'(rate_sel) * RR_W'(rate_sel);
    assign p        = P_W'(s_reg) * P_W'(rr_reg);

    // one root bit per step: bring down two radicand bits, try 4*root+1
    assign rem_sh   = {rem_reg[REM_W-3:0], n_reg[N_W-1 -: 2]};
    assign trial    = REM_W'({root_reg, 2'b01});

    assign root_sat = root_reg[ROOT_W-1] ? FEED_MAX : root_reg[FEED_W-1:0];
    assign fm       = FM_W'(root_sat) * FM_W'(ms_reg);

    assign mag_sel    = mag[cmd.axis];
    assign x_full     = 32'(mag_sel) * 32'(fm_reg);
    assign recip_prod = (X_W+32)'(x_reg) * (X_W+32)'(RECIP_M);
    assign q0k        = 32'(q0_reg) * MOVE_DIV;
    assign rem_d      = 32'(x_reg) - q0k;
    assign q          = (rem_d >= MOVE_DIV) ? q0_reg + 1'b1 : q0_reg;

    assign ms_clamp = (elapsed_ms > MS_W'(MS_MAX)) ? MS_MAX : elapsed_ms[MSC_W-1:0];

    always_comb
    begin
        case (cmd.axis)
            2'd0:    lim_sel = cfg.limit_x;
            2'd1:    lim_sel = cfg.limit_y;
            default: lim_sel = cfg.limit_z;
        endcase
    end

    assign cur_sel      = cur_reg[cmd.axis];
    assign neg          = spd_reg[cmd.axis][SPD_W-1];
    assign before_bound = (cur_sel == '0) || (cur_sel >= lim_sel);
    assign under        = neg && ((POS_W+1)'(q_reg) > (POS_W+1)'(cur_sel));
    assign sum          = neg ? (POS_W+1)'(cur_sel) - (POS_W+1)'(q_reg)
                              : (POS_W+1)'(cur_sel) + (POS_W+1)'(q_reg);
    assign over         = !under && (sum > (POS_W+1)'(lim_sel));
    assign new_pos      = under ? '0 : (over ? lim_sel : sum[POS_W-1:0]);

    assign stat.is_load     = op_reg;
    assign stat.go          = (p_reg >= P_MIN);
    assign stat.out_blocked = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
                cur_reg[a] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && op)
            begin
                cur_reg[0] <= load_x;
                cur_reg[1] <= load_y;
                cur_reg[2] <= load_z;
            end
            else if (cmd.upd)
                cur_reg[cmd.axis] <= new_pos;

            if (cmd.result)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= op;
            spd_reg[0] <= speed_x;
            spd_reg[1] <= speed_y;
            spd_reg[2] <= speed_z;
            ms_reg     <= ms_clamp;
            moved_reg  <= 1'b0;
            rumble_reg <= 1'b0;
            feed_reg   <= '0;
            p_reg      <= '0;
        end
        if (cmd.prep)
        begin
            s_reg  <= s_sum;
            rr_reg <= rr;
        end
        if (cmd.prod)
        begin
            p_reg    <= p;
            n_reg    <= {p, 8'h00};
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            n_reg <= n_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.feed)
        begin
            feed_reg  <= root_sat;
            fm_reg    <= fm;
            moved_reg <= 1'b1;
        end
        if (cmd.mul)
            x_reg <= x_full[X_W-1:0];
        if (cmd.recip)
            q0_reg <= recip_prod[RECIP_SH+Q_W-1:RECIP_SH];
        if (cmd.corr)
            q_reg <= q;
        if (cmd.upd && (under || over) && !before_bound)
            rumble_reg <= 1'b1;
        if (cmd.result)
        begin
            out_moved_reg  <= moved_reg;
            out_pos_reg[0] <= cur_reg[0];
            out_pos_reg[1] <= cur_reg[1];
            out_pos_reg[2] <= cur_reg[2];
            out_feed_reg   <= feed_reg;
            out_rumble_reg <= rumble_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign moved     = out_moved_reg;
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign feed      = out_feed_reg;
    assign rumble    = out_rumble_reg;

endmodule

`default_nettype wire

@@ hw/rtl/jog_position_integrator_top.sv @@
`default_nettype none

// Three-axis jog position integrator. One item is worked on at a time and a
// finished result sits in an output register, so the next item is taken while
// the previous result waits. A moving jog tick runs the bit-per-cycle square
// root that forms the feedrate, then the per-axis sequence of distance
// multiply, reciprocal divide by 4000, correction and clamped position update,
// run once for each axis; a load item or a jog tick below the motion threshold
// skips both. Configuration registers sit at byte addresses 0, 4, 8, 12 and
// 16; the user must write them only while no item is in flight, as the block
// itself does not enforce this.
module jog_position_integrator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jpi_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic signed [jpi_pkg::SPD_W-1:0]  speed_x,
    input  logic signed [jpi_pkg::SPD_W-1:0]  speed_y,
    input  logic signed [jpi_pkg::SPD_W-1:0]  speed_z,
    input  logic [jpi_pkg::MS_W-1:0]          elapsed_ms,
    input  jpi_pkg::pos_t                     load_x,
    input  jpi_pkg::pos_t                     load_y,
    input  jpi_pkg::pos_t                     load_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              moved,
    output jpi_pkg::pos_t                     pos_x,
    output jpi_pkg::pos_t                     pos_y,
    output jpi_pkg::pos_t                     pos_z,
    output logic [jpi_pkg::FEED_W-1:0]        feed,
    output logic                              rumble
);
    import jpi_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    jpi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    jpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    jpi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg        (cfg),
        .op         (op),
        .speed_x    (speed_x),
        .speed_y    (speed_y),
        .speed_z    (speed_z),
        .elapsed_ms (elapsed_ms),
        .load_x     (load_x),
        .load_y     (load_y),
        .load_z     (load_z),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .moved      (moved),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .feed       (feed),
        .rumble     (rumble)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the input side closed on the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    a_still_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !moved) |-> (feed == '0 && !rumble))
        else $error("result without motion carries feed or rumble");

    a_moving_feed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && moved) |-> (feed != '0))
        else $error("moving result with zero feed");
`endif

endmodule

`default_nettype wire
